/* design/rod_heat_diffusion_step_defines.svh */
// assertion helpers for the rod heat diffusion block
`ifndef ROD_HEAT_DIFFUSION_STEP_DEFINES_SVH
`define ROD_HEAT_DIFFUSION_STEP_DEFINES_SVH

`ifndef SYNTHESIS
`define RHD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RHD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `RHD_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define RHD_ASSERT(lbl, clk, rstn, prop, msg)
`define RHD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* design/rhd_pkg.sv */
package rhd_pkg;

  localparam int MaxSegments = 128;
  localparam int IdxW        = $clog2(MaxSegments);
  localparam int CntW        = $clog2(MaxSegments + 1);
  localparam int TempW       = 32;
  localparam int TotW        = 39;
  localparam int RegW        = 32;
  localparam int NumRegs     = 6;
  localparam int PAddrW      = $clog2(NumRegs * 4);

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic signed [TempW:0]   wide_t;
  typedef logic        [31:0]      gain_t;
  typedef logic signed [TotW-1:0]  tot_t;

  // input action codes
  localparam logic ActFill = 1'b0;
  localparam logic ActStep = 1'b1;

  typedef enum logic [PAddrW-3:0] {
    RegAmbient  = 3'd0,
    RegMax      = 3'd1,
    RegCond     = 3'd2,
    RegLoss     = 3'd3,
    RegEndLoss  = 3'd4,
    RegSegments = 3'd5
  } reg_idx_e;

  localparam temp_t      AmbientReset  = 32'sd1310720;
  localparam temp_t      MaxReset      = 32'sd19660800;
  localparam gain_t      CondReset     = 32'd134217728;
  localparam gain_t      LossReset     = 32'd18454;
  localparam gain_t      EndLossReset  = 32'd0;
  localparam logic [7:0] SegmentsReset = 8'd100;

  typedef struct packed {
    temp_t      ambient_temp;
    temp_t      max_temp;
    gain_t      conduction_gain;
    gain_t      loss_gain;
    gain_t      end_loss_gain;
    logic [7:0] segments_used;
  } cfg_t;

  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    temp_t           wdata;
    logic            clr;
    temp_t           clr_val;
  } mem_req_t;

  function automatic wide_t ext33(temp_t t);
    return {t[TempW-1], t};
  endfunction

  function automatic wide_t add33(temp_t a, temp_t b);
    return ext33(a) + ext33(b);
  endfunction

  function automatic wide_t sub33(temp_t a, temp_t b);
    return ext33(a) - ext33(b);
  endfunction

  function automatic temp_t sat32(wide_t v);
    temp_t r;
    if (v[TempW] != v[TempW-1]) begin
      r = v[TempW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[TempW-1:0];
    end
    return r;
  endfunction

  // below ambient first, then above max
  function automatic temp_t clamp_temp(wide_t v, temp_t lo, temp_t hi);
    temp_t r;
    if (v < ext33(lo)) begin
      r = lo;
    end else if (v > ext33(hi)) begin
      r = hi;
    end else begin
      r = v[TempW-1:0];
    end
    return r;
  endfunction

  function automatic logic [IdxW-1:0] last_index(logic [7:0] su);
    int unsigned cnt;
    cnt = 32'(su);
    if (cnt == 0) cnt = 1;
    if (cnt > MaxSegments) cnt = MaxSegments;
    return IdxW'(cnt - 1);
  endfunction

endpackage

/* design/rhd_if.sv */
interface rhd_step_if;
  import rhd_pkg::*;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] time_step;
  temp_t       heat_rate;

  modport source (output valid, action, time_step, heat_rate, input ready);
  modport sink (input valid, action, time_step, heat_rate, output ready);
endinterface

interface rhd_result_if;
  import rhd_pkg::*;
  logic  valid;
  logic  ready;
  temp_t end_temp;
  tot_t  total_temp;

  modport source (output valid, end_temp, total_temp, input ready);
  modport sink (input valid, end_temp, total_temp, output ready);
endinterface

/* design/rhd_cfg_regs.sv */
module rhd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rhd_pkg::PAddrW-1:0] paddr,
  input  logic [rhd_pkg::RegW-1:0]   pwdata,
  output logic [rhd_pkg::RegW-1:0]   prdata,
  output logic                       pready,
  output rhd_pkg::cfg_t              cfg_o
);
  import rhd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegAmbient:  cfg_d.ambient_temp    = pwdata;
        RegMax:      cfg_d.max_temp        = pwdata;
        RegCond:     cfg_d.conduction_gain = pwdata;
        RegLoss:     cfg_d.loss_gain       = pwdata;
        RegEndLoss:  cfg_d.end_loss_gain   = pwdata;
        RegSegments: cfg_d.segments_used   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegAmbient:  prdata = cfg_q.ambient_temp;
      RegMax:      prdata = cfg_q.max_temp;
      RegCond:     prdata = cfg_q.conduction_gain;
      RegLoss:     prdata = cfg_q.loss_gain;
      RegEndLoss:  prdata = cfg_q.end_loss_gain;
      RegSegments: prdata = {{(RegW-8){1'b0}}, cfg_q.segments_used};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ambient_temp    <= AmbientReset;
      cfg_q.max_temp        <= MaxReset;
      cfg_q.conduction_gain <= CondReset;
      cfg_q.loss_gain       <= LossReset;
      cfg_q.end_loss_gain   <= EndLossReset;
      cfg_q.segments_used   <= SegmentsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/rhd_seg_mem.sv */
module rhd_seg_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rhd_pkg::mem_req_t req_i,
  output rhd_pkg::temp_t    rdata_o
);
  import rhd_pkg::*;

  temp_t                  mem [MaxSegments];
  logic [MaxSegments-1:0] valid_q;
  temp_t                  fill_q;
  temp_t                  rd_q;
  logic                   rd_valid_q;

  // entries not written since the last fill read as the fill value
  assign rdata_o = rd_valid_q ? rd_q : fill_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      fill_q     <= AmbientReset;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
        fill_q  <= req_i.clr_val;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

endmodule

/* design/rhd_mulq.sv */
module rhd_mulq (
  input  logic           clk_i,
  input  rhd_pkg::wide_t a_i,
  input  rhd_pkg::gain_t g_i,
  output rhd_pkg::temp_t res_o
);
  import rhd_pkg::*;

  logic [TempW:0]       mag_d, mag_q;
  logic                 neg_q, neg2_q;
  gain_t                g_q;
  logic [2*TempW:0]     prod_q;
  logic [TempW+8:0]     p;
  logic                 big;

  // magnitude of q16.16 operand, sign kept aside
  assign mag_d = a_i[TempW] ? (TempW+1)'(-a_i) : a_i;

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= a_i[TempW];
    g_q    <= g_i;
    prod_q <= (2*TempW+1)'(mag_q) * (2*TempW+1)'(g_q);
    neg2_q <= neg_q;
  end

  // drop 24 fraction bits, truncate toward zero, saturate
  assign p   = prod_q[2*TempW:24];
  assign big = |p[TempW+8:TempW-1];

  always_comb begin
    if (neg2_q) begin
      res_o = big ? 32'sh8000_0000 : -p[TempW-1:0];
    end else begin
      res_o = big ? 32'sh7fff_ffff : p[TempW-1:0];
    end
  end

endmodule

/* design/rod_heat_diffusion_step.sv */
// sequencing: a fill item goes from idle straight to done; an advance item walks each
// used segment twice through the shared multiplier, in segment states StSegA to StSegG,
// plus per-pass head (StPre0 to StPre7) and tail (StEnd1 to StEnd4) work
// throughput: one item at a time, next item taken as soon as the sequencer returns to idle
// reset: config registers take their reset values, all segments read as 20.0 at once
`include "rod_heat_diffusion_step_defines.svh"

module rod_heat_diffusion_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rhd_step_if.sink                   step_i,
  rhd_result_if.source               result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rhd_pkg::PAddrW-1:0] paddr,
  input  logic [rhd_pkg::RegW-1:0]   pwdata,
  output logic [rhd_pkg::RegW-1:0]   prdata,
  output logic                       pready
);
  import rhd_pkg::*;

  localparam int FillW = TempW + CntW + 1;

  // sequencer, one-hot
  typedef enum logic [20:0] {
    StIdle = 21'h000001,
    StPre0 = 21'h000002,
    StPre1 = 21'h000004,
    StPre2 = 21'h000008,
    StPre3 = 21'h000010,
    StPre4 = 21'h000020,
    StPre5 = 21'h000040,
    StPre6 = 21'h000080,
    StPre7 = 21'h000100,
    StSegA = 21'h000200,
    StSegB = 21'h000400,
    StSegC = 21'h000800,
    StSegD = 21'h001000,
    StSegE = 21'h002000,
    StSegF = 21'h004000,
    StSegG = 21'h008000,
    StEnd1 = 21'h010000,
    StEnd2 = 21'h020000,
    StEnd3 = 21'h040000,
    StEnd4 = 21'h080000,
    StDone = 21'h100000
  } state_e;

  state_e          state_q, state_d;
  logic            pass_q, pass_d;
  logic            out_valid_q, out_valid_d;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] last_q, last_d;
  gain_t           dt1_q, dt1_d;
  temp_t           heat_q, heat_d;
  temp_t           cur_q, cur_d;     // old value of segment idx
  temp_t           nxt_q, nxt_d;     // old value of segment idx+1
  temp_t           fl_q, fl_d;       // flow from the left neighbor
  temp_t           fr_q, fr_d;       // flow toward the right neighbor
  temp_t           q1_q, q1_d;       // loss toward ambient
  temp_t           q2_q, q2_d;       // net conduction, saturated
  temp_t           v_q, v_d;         // clamped value of the last segment
  tot_t            acc_q, acc_d;
  temp_t           end_q, end_d;
  temp_t           out_end_q, out_end_d;
  tot_t            out_tot_q, out_tot_d;

  cfg_t            cfg;
  mem_req_t        mem_req;
  temp_t           rdata;
  wide_t           mul_a;
  gain_t           mul_g;
  temp_t           mres;

  logic [IdxW-1:0]        last_cfg;
  logic [CntW-1:0]        n_fill;
  logic signed [FillW-1:0] fill_prod;
  logic                   out_load;
  logic                   has_right;
  logic                   rw_clash;

  rhd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // segment store: one write and one read port, registered read data
  rhd_seg_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // shared q16.16 x q8.24 multiplier, operands and product registered before the result
  rhd_mulq u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .g_i   (mul_g),
    .res_o (mres)
  );

  // a fill answers with ambient in every used segment: total is ambient times n
  assign last_cfg  = last_index(cfg.segments_used);
  assign n_fill    = CntW'(last_cfg) + 1'b1;
  assign fill_prod = FillW'(cfg.ambient_temp) * FillW'($signed({1'b0, n_fill}));

  assign has_right = (idx_q != last_q);
  assign out_load  = (state_q == StDone) && (!out_valid_q || result_o.ready);

  assign step_i.ready        = (state_q == StIdle);
  assign result_o.valid      = out_valid_q;
  assign result_o.end_temp   = out_end_q;
  assign result_o.total_temp = out_tot_q;

  always_comb begin
    temp_t fr_v;
    temp_t nv;
    temp_t w_v;

    state_d   = state_q;
    pass_d    = pass_q;
    idx_d     = idx_q;
    last_d    = last_q;
    dt1_d     = dt1_q;
    heat_d    = heat_q;
    cur_d     = cur_q;
    nxt_d     = nxt_q;
    fl_d      = fl_q;
    fr_d      = fr_q;
    q1_d      = q1_q;
    q2_d      = q2_q;
    v_d       = v_q;
    acc_d     = acc_q;
    end_d     = end_q;
    mem_req   = '0;
    mul_a     = '0;
    mul_g     = '0;
    fr_v      = '0;
    nv        = clamp_temp(add33(cur_q, mres), cfg.ambient_temp, cfg.max_temp);
    w_v       = sat32(sub33(v_q, mres));

    case (state_q)
      StIdle: begin
        if (step_i.valid) begin
          last_d = last_cfg;
          if (step_i.action == ActFill) begin
            // fill: drop every valid bit, store ambient as the new fill value
            mem_req.clr     = 1'b1;
            mem_req.clr_val = cfg.ambient_temp;
            end_d           = cfg.ambient_temp;
            acc_d           = TotW'(fill_prod);
            state_d         = StDone;
          end else begin
            dt1_d   = step_i.time_step >> 1;
            heat_d  = step_i.heat_rate;
            pass_d  = 1'b0;
            acc_d   = '0;
            state_d = StPre0;
          end
        end
      end
      // head of a half step: heat in and end loss on segment 0, kept in cur
      StPre0: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = '0;
        mul_a         = ext33(heat_q);
        mul_g         = dt1_q;
        state_d       = StPre1;
      end
      StPre1: state_d = StPre2;
      StPre2: begin
        cur_d   = sat32(add33(rdata, mres));
        state_d = StPre3;
      end
      StPre3: begin
        mul_a   = sub33(cur_q, cfg.ambient_temp);
        mul_g   = cfg.end_loss_gain;
        state_d = StPre4;
      end
      StPre4: state_d = StPre5;
      StPre5: begin
        mul_a   = ext33(mres);
        mul_g   = dt1_q;
        state_d = StPre6;
      end
      StPre6: state_d = StPre7;
      StPre7: begin
        cur_d   = sat32(sub33(cur_q, mres));
        fl_d    = '0;
        idx_d   = '0;
        state_d = StSegA;
      end
      // per segment: loss, right flow (reused as next segment's left flow), update
      StSegA: begin
        mul_a = sub33(cur_q, cfg.ambient_temp);
        mul_g = cfg.loss_gain;
        if (has_right) begin
          // read ahead of the write pointer, so the old value comes back
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_q + 1'b1;
        end
        state_d = StSegB;
      end
      StSegB: begin
        if (has_right) begin
          nxt_d = rdata;
          mul_a = sub33(cur_q, rdata);
          mul_g = cfg.conduction_gain;
        end
        state_d = StSegC;
      end
      StSegC: begin
        q1_d    = mres;
        state_d = StSegD;
      end
      StSegD: begin
        fr_v    = has_right ? mres : '0;
        fr_d    = fr_v;
        q2_d    = sat32(sub33(fl_q, fr_v));
        state_d = StSegE;
      end
      StSegE: begin
        mul_a   = sub33(q2_q, q1_q);
        mul_g   = dt1_q;
        state_d = StSegF;
      end
      StSegF: state_d = StSegG;
      StSegG: begin
        if (has_right) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = idx_q;
          mem_req.wdata = nv;
          if (pass_q) begin
            acc_d = acc_q + TotW'(nv);
          end
          cur_d   = nxt_q;
          fl_d    = fr_q;
          idx_d   = idx_q + 1'b1;
          state_d = StSegA;
        end else begin
          // last segment: end loss from its old value, taken after the clamp
          v_d     = nv;
          mul_a   = sub33(cur_q, cfg.ambient_temp);
          mul_g   = cfg.end_loss_gain;
          state_d = StEnd1;
        end
      end
      StEnd1: state_d = StEnd2;
      StEnd2: begin
        mul_a   = ext33(mres);
        mul_g   = dt1_q;
        state_d = StEnd3;
      end
      StEnd3: state_d = StEnd4;
      StEnd4: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = last_q;
        mem_req.wdata = w_v;
        end_d         = w_v;
        if (pass_q) begin
          acc_d   = acc_q + TotW'(w_v);
          state_d = StDone;
        end else begin
          pass_d  = 1'b1;
          state_d = StPre0;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // output register: the next item may start while this result waits
  always_comb begin
    out_valid_d = out_valid_q;
    out_end_d   = out_end_q;
    out_tot_d   = out_tot_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_end_d   = end_q;
      out_tot_d   = acc_q;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    last_q    <= last_d;
    dt1_q     <= dt1_d;
    heat_q    <= heat_d;
    cur_q     <= cur_d;
    nxt_q     <= nxt_d;
    fl_q      <= fl_d;
    fr_q      <= fr_d;
    q1_q      <= q1_d;
    q2_q      <= q2_d;
    v_q       <= v_d;
    acc_q     <= acc_d;
    end_q     <= end_d;
    out_end_q <= out_end_d;
    out_tot_q <= out_tot_d;
  end

  // the read-ahead must never meet the write-behind on one entry
  assign rw_clash = mem_req.re && mem_req.we && (mem_req.raddr == mem_req.waddr);
  `RHD_ASSERT_NEVER(a_rw_same_entry, clk_i, rst_ni, rw_clash, "read and write hit one entry")
  // a fill may only clear the store between items
  `RHD_ASSERT(a_clear_when_idle, clk_i, rst_ni,
              mem_req.clr |-> (state_q == StIdle), "segment store cleared while busy")
  // the segment walk stays inside the used segments
  `RHD_ASSERT(a_idx_in_range, clk_i, rst_ni,
              (state_q == StSegA) |-> (idx_q <= last_q), "segment index past last segment")
  // a result only appears after the sequencer finished an item
  `RHD_ASSERT(a_result_from_done, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(state_q == StDone), "result raised outside done")

endmodule
